### design/assert_macros.svh
// assertion macros for the checker in rrss_checker.sv
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, switched off while reset is low
`define RRSS_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("rrss assertion failed");

// clocked assertion that is also checked during reset
`define RRSS_ASSERT_RST(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("rrss reset assertion failed");

`endif

### design/rrss_pkg.sv
package rrss_pkg;

    // queue geometry
    localparam int QUEUE_DEPTH = 16;
    localparam int IDX_W       = $clog2(QUEUE_DEPTH);
    localparam int OCC_W       = $clog2(QUEUE_DEPTH + 1);

    // configuration space
    localparam int          ADDR_W        = 2;
    localparam logic [ADDR_W-1:0] ADDR_QUANTUM = 2'd0;
    localparam logic [15:0] QUANTUM_RESET = 16'd5;

    // request kinds
    localparam logic KIND_ADD      = 1'b0;
    localparam logic KIND_DISPATCH = 1'b1;

    typedef enum logic [1:0] {
        ST_ADDED = 2'd0,
        ST_FULL  = 2'd1,
        ST_RUN   = 2'd2,
        ST_EMPTY = 2'd3
    } t_status;

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } t_state;

    typedef struct packed {
        logic        kind;
        logic [15:0] burst_time;
    } t_req;

    typedef struct packed {
        t_status     status;
        logic [15:0] job_id;
        logic [31:0] slice_wait;
        logic        finished;
        logic [15:0] remaining_after;
        logic [31:0] clock_after;
        logic [31:0] total_wait;
        logic [15:0] jobs_done;
    } t_rsp;

    // one ready queue entry
    typedef struct packed {
        logic [15:0] id;
        logic [15:0] remaining;
        logic [31:0] wait_since;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    // controller to datapath
    typedef struct packed {
        logic accept;
        logic commit;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic out_free;
    } t_stat;

    // circular index advance
    function automatic logic [IDX_W-1:0] next_index(input logic [IDX_W-1:0] idx);
        logic [IDX_W-1:0] res;
        if (idx == IDX_W'(QUEUE_DEPTH - 1)) begin
            res = '0;
        end else begin
            res = idx + 1'b1;
        end
        return res;
    endfunction

endpackage

### design/rrss_ram.sv
module rrss_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### design/rrss_datapath.sv
module rrss_datapath (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  rrss_pkg::t_cmd     i_cmd,
    output rrss_pkg::t_stat    o_stat,
    input  rrss_pkg::t_req     i_req,
    output rrss_pkg::t_rsp     o_rsp,
    output logic               o_valid,
    input  logic               i_ready,
    input  logic               i_cfg_wr,
    input  logic [15:0]        i_cfg_data,
    output logic [15:0]        o_quantum
);

    // control and bookkeeping state
    logic [rrss_pkg::IDX_W-1:0] r_head, n_head;
    logic [rrss_pkg::IDX_W-1:0] r_tail, n_tail;
    logic [rrss_pkg::OCC_W-1:0] r_occ, n_occ;
    logic [31:0]                r_clock, n_clock;
    logic [15:0]                r_next_id, n_next_id;
    logic [31:0]                r_total, n_total;
    logic [15:0]                r_done, n_done;
    logic [15:0]                r_quantum;
    logic                       r_out_valid;

    // payload registers
    rrss_pkg::t_req             r_req;
    rrss_pkg::t_rsp             r_rsp, n_rsp;

    // queue memory signals
    logic                       wr_en;
    rrss_pkg::t_entry           wr_entry;
    rrss_pkg::t_entry           rd_entry;
    logic [rrss_pkg::ENTRY_W-1:0] rd_bits;

    logic [31:0] wait_cur;
    logic [32:0] total_sum;
    logic [16:0] done_inc;
    logic        is_full;
    logic        is_empty;

    rrss_ram #(
        .WIDTH (rrss_pkg::ENTRY_W),
        .DEPTH (rrss_pkg::QUEUE_DEPTH)
    ) u_queue (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_tail),
        .i_wr_data (wr_entry),
        .i_rd_en   (i_cmd.accept),
        .i_rd_addr (r_head),
        .o_rd_data (rd_bits)
    );

    assign rd_entry = rd_bits;

    // queue condition and slice arithmetic
    assign is_full   = (r_occ == rrss_pkg::OCC_W'(rrss_pkg::QUEUE_DEPTH));
    assign is_empty  = (r_occ == '0);
    assign wait_cur  = r_clock - rd_entry.wait_since;
    assign total_sum = {1'b0, r_total} + {1'b0, wait_cur};
    assign done_inc  = {1'b0, r_done} + 17'd1;

    // next state for one committed request
    always_comb begin
        n_head    = r_head;
        n_tail    = r_tail;
        n_occ     = r_occ;
        n_clock   = r_clock;
        n_next_id = r_next_id;
        n_total   = r_total;
        n_done    = r_done;
        wr_en     = 1'b0;
        wr_entry  = '0;
        n_rsp     = '0;

        if (r_req.kind == rrss_pkg::KIND_ADD) begin
            if (is_full) begin
                n_rsp.status = rrss_pkg::ST_FULL;
            end else begin
                n_rsp.status        = rrss_pkg::ST_ADDED;
                n_rsp.job_id        = r_next_id;
                wr_en               = i_cmd.commit;
                wr_entry.id         = r_next_id;
                wr_entry.remaining  = r_req.burst_time;
                wr_entry.wait_since = r_clock;
                n_next_id           = r_next_id + 16'd1;
                n_tail              = rrss_pkg::next_index(r_tail);
                n_occ               = r_occ + 1'b1;
            end
        end else if (is_empty) begin
            n_rsp.status = rrss_pkg::ST_EMPTY;
        end else begin
            n_rsp.status     = rrss_pkg::ST_RUN;
            n_rsp.job_id     = rd_entry.id;
            n_rsp.slice_wait = wait_cur;
            n_head           = rrss_pkg::next_index(r_head);
            n_total          = total_sum[32] ? 32'hFFFF_FFFF : total_sum[31:0];
            if (rd_entry.remaining <= r_quantum) begin
                // job completes within this slice
                n_clock        = r_clock + {16'd0, rd_entry.remaining};
                n_done         = done_inc[16] ? r_done : done_inc[15:0];
                n_rsp.finished = 1'b1;
                n_occ          = r_occ - 1'b1;
            end else begin
                // job goes back to the tail with a new stamp
                n_clock               = r_clock + {16'd0, r_quantum};
                n_rsp.remaining_after = rd_entry.remaining - r_quantum;
                wr_en                 = i_cmd.commit;
                wr_entry.id           = rd_entry.id;
                wr_entry.remaining    = rd_entry.remaining - r_quantum;
                wr_entry.wait_since   = r_clock + {16'd0, r_quantum};
                n_tail                = rrss_pkg::next_index(r_tail);
            end
        end
        n_rsp.clock_after = n_clock;
        n_rsp.total_wait  = n_total;
        n_rsp.jobs_done   = n_done;
    end

    // scheduler state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head    <= '0;
            r_tail    <= '0;
            r_occ     <= '0;
            r_clock   <= '0;
            r_next_id <= 16'd1;
            r_total   <= '0;
            r_done    <= '0;
        end else if (i_cmd.commit) begin
            r_head    <= n_head;
            r_tail    <= n_tail;
            r_occ     <= n_occ;
            r_clock   <= n_clock;
            r_next_id <= n_next_id;
            r_total   <= n_total;
            r_done    <= n_done;
        end
    end

    // quantum register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_quantum <= rrss_pkg::QUANTUM_RESET;
        end else if (i_cfg_wr) begin
            r_quantum <= i_cfg_data;
        end
    end

    // request capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_req <= i_req;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.commit) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_rsp <= n_rsp;
        end
    end

    assign o_stat.out_free = !r_out_valid || i_ready;
    assign o_valid         = r_out_valid;
    assign o_rsp           = r_rsp;
    assign o_quantum       = r_quantum;

endmodule

### design/rrss_ctrl.sv
module rrss_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  rrss_pkg::t_stat i_stat,
    output rrss_pkg::t_cmd  o_cmd
);

    rrss_pkg::t_state r_state, n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rrss_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and commands
    always_comb begin
        n_state      = r_state;
        o_cmd.accept = 1'b0;
        o_cmd.commit = 1'b0;
        o_ready      = 1'b0;
        unique case (r_state)
            rrss_pkg::S_IDLE: begin
                o_ready      = 1'b1;
                o_cmd.accept = i_valid;
                if (i_valid) begin
                    n_state = rrss_pkg::S_EXEC;
                end
            end
            rrss_pkg::S_EXEC: begin
                // hold until the result register can take the answer
                o_cmd.commit = i_stat.out_free;
                if (i_stat.out_free) begin
                    n_state = rrss_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = rrss_pkg::S_IDLE;
            end
        endcase
    end

endmodule

### design/round_robin_slice_scheduler_unit.sv
// Round-robin time-slice scheduler. Add requests append a job to a circular
// ready queue of rrss_pkg::QUEUE_DEPTH entries; dispatch requests pop the head,
// charge its wait, run one quantum and finish it or put it back at the tail.
// Each request passes the accept state, which reads the queue head from the
// registered-read queue memory, then the execute state, which updates the queue
// and loads the result register. A request is taken while an earlier result
// still waits in the result register; the execute state holds only while that
// result has not been taken. A new request is taken only once the execute
// state is done. The queue memory needs no clearing after reset. The time
// quantum register sits at byte address 0 of the APB port and resets to 5.
module round_robin_slice_scheduler_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  rrss_pkg::t_req                i_req,
    output logic                          o_valid,
    input  logic                          i_ready,
    output rrss_pkg::t_rsp                o_rsp,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [rrss_pkg::ADDR_W-1:0]   paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    rrss_pkg::t_cmd  cmd;
    rrss_pkg::t_stat stat;
    logic            cfg_wr;
    logic [15:0]     quantum;

    // register decode
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr == rrss_pkg::ADDR_QUANTUM);
    assign prdata = (paddr == rrss_pkg::ADDR_QUANTUM) ? {16'd0, quantum} : 32'd0;

    rrss_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    rrss_datapath u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_stat     (stat),
        .i_req      (i_req),
        .o_rsp      (o_rsp),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .i_cfg_wr   (cfg_wr),
        .i_cfg_data (pwdata[15:0]),
        .o_quantum  (quantum)
    );

endmodule

### design/rrss_checker.sv
`include "assert_macros.svh"

module rrss_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           i_valid,
    input logic           o_ready,
    input logic           o_valid,
    input logic           i_ready,
    input rrss_pkg::t_rsp o_rsp
);

    // a held result keeps its value
    `RRSS_ASSERT(a_rsp_hold, i_clk, i_rst_n, o_valid && !i_ready |=> o_valid && $stable(o_rsp))

    // one request in flight: no accept right after an accept
    `RRSS_ASSERT(a_one_in_flight, i_clk, i_rst_n, i_valid && o_ready |=> !o_ready)

    // an empty dispatch reports no job
    `RRSS_ASSERT(a_empty_clean, i_clk, i_rst_n, o_valid && o_rsp.status == rrss_pkg::ST_EMPTY |-> o_rsp.job_id == 16'd0 && o_rsp.slice_wait == 32'd0 && !o_rsp.finished && o_rsp.remaining_after == 16'd0)

    // a finished job has nothing left and came from a slice run
    `RRSS_ASSERT(a_finish_zero, i_clk, i_rst_n, o_valid && o_rsp.finished |-> o_rsp.status == rrss_pkg::ST_RUN && o_rsp.remaining_after == 16'd0)

    // reset drops any pending result
    `RRSS_ASSERT_RST(a_reset_clear, i_clk, !i_rst_n |=> !o_valid)

endmodule

bind round_robin_slice_scheduler_unit rrss_checker u_rrss_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (i_valid),
    .o_ready (o_ready),
    .o_valid (o_valid),
    .i_ready (i_ready),
    .o_rsp   (o_rsp)
);
